/* rtl/apgi_pkg.sv */
package apgi_pkg;

    localparam int VALUE_BITS = 31;
    localparam int TDATA_BITS = ((VALUE_BITS + 7) / 8) * 8;
    localparam int SHIFT_BITS = $clog2(VALUE_BITS);
    localparam int UPC_BITS   = 3;

    typedef logic [VALUE_BITS-1:0] value_t;
    typedef logic [SHIFT_BITS-1:0] shift_t;
    typedef logic [UPC_BITS-1:0]   upc_t;

    // datapath operation of one microcode step
    typedef enum logic [2:0]
    {
        OP_LOAD      = 3'd0,
        OP_ZERO      = 3'd1,
        OP_STEP      = 3'd2,
        OP_FINISH    = 3'd3,
        OP_EMIT_GCD  = 3'd4,
        OP_EMIT_ELEM = 3'd5
    } op_t;

    // branch rule of one microcode step
    typedef enum logic [2:0]
    {
        J_NEXT     = 3'd0,
        J_ALWAYS   = 3'd1,
        J_NO_PREV  = 3'd2,
        J_ANY_ZERO = 3'd3,
        J_NOT_EQ   = 3'd4
    } jcond_t;

    typedef struct packed
    {
        op_t    op;
        jcond_t cond;
        upc_t   target;
    } uword_t;

    localparam upc_t STEP_LOAD   = 3'd0;
    localparam upc_t STEP_ZERO   = 3'd1;
    localparam upc_t STEP_LOOP   = 3'd2;
    localparam upc_t STEP_FINISH = 3'd3;
    localparam upc_t STEP_GCD    = 3'd4;
    localparam upc_t STEP_ELEM   = 3'd5;

    function automatic uword_t ucode_rom(input upc_t addr);
        uword_t w;
        case (addr)
            STEP_LOAD:   w = '{OP_LOAD,      J_NO_PREV,  STEP_ELEM};
            STEP_ZERO:   w = '{OP_ZERO,      J_ANY_ZERO, STEP_GCD};
            STEP_LOOP:   w = '{OP_STEP,      J_NOT_EQ,   STEP_LOOP};
            STEP_FINISH: w = '{OP_FINISH,    J_NEXT,     STEP_GCD};
            STEP_GCD:    w = '{OP_EMIT_GCD,  J_NEXT,     STEP_ELEM};
            STEP_ELEM:   w = '{OP_EMIT_ELEM, J_ALWAYS,   STEP_LOAD};
            default:     w = '{OP_EMIT_ELEM, J_ALWAYS,   STEP_LOAD};
        endcase
        return w;
    endfunction

endpackage

/* rtl/adjacent_pair_gcd_interleave.sv */
// steps: the load step accepts an item; the first item of a sequence goes straight to
// the element emit step, later items pass the zero check and, unless a value is zero,
// the binary gcd loop and the finish step, then emit the gcd and then the element
// throughput: one item at a time; the next item is taken only after the element emit,
// and the emit steps wait while the result side stalls
// reset: rst_n clears the sequencer, output valid and the previous-element state
module adjacent_pair_gcd_interleave
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [apgi_pkg::TDATA_BITS-1:0]   s_axis_tdata,  // value, pad bits ignored
    input  logic                              s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [apgi_pkg::TDATA_BITS-1:0]   m_axis_tdata,  // value_out, zero pad
    output logic                              m_axis_tuser,  // is_gcd
    output logic                              m_axis_tlast
);

    apgi_pkg::upc_t   upc_reg, upc_next;
    apgi_pkg::uword_t uw;
    apgi_pkg::value_t a_reg, a_next;
    apgi_pkg::value_t b_reg, b_next;
    apgi_pkg::shift_t k_reg, k_next;
    apgi_pkg::value_t cur_reg, cur_next;
    logic             cur_last_reg, cur_last_next;
    apgi_pkg::value_t prev_reg, prev_next;
    logic             have_prev_reg, have_prev_next;

    logic             out_valid_reg, out_valid_next;
    apgi_pkg::value_t out_data_reg, out_data_next;
    logic             out_gcd_reg, out_gcd_next;
    logic             out_last_reg, out_last_next;

    logic             out_free;
    logic             stall;
    logic             jump;
    logic             a_eq_b;
    logic             any_zero;
    apgi_pkg::value_t a_minus_b;
    apgi_pkg::value_t b_minus_a;
    logic             a_lt_b;

    assign uw       = apgi_pkg::ucode_rom(upc_reg);
    assign out_free = !out_valid_reg || m_axis_tready;

    assign a_eq_b    = (a_reg == b_reg);
    assign any_zero  = (a_reg == '0) || (b_reg == '0);
    assign a_lt_b    = (a_reg < b_reg);
    assign a_minus_b = a_reg - b_reg;
    assign b_minus_a = b_reg - a_reg;

    assign s_axis_tready = (uw.op == apgi_pkg::OP_LOAD);

    always_comb
    begin
        case (uw.op)
            apgi_pkg::OP_LOAD:      stall = !s_axis_tvalid;
            apgi_pkg::OP_EMIT_GCD:  stall = !out_free;
            apgi_pkg::OP_EMIT_ELEM: stall = !out_free;
            default:                stall = 1'b0;
        endcase
    end

    always_comb
    begin
        case (uw.cond)
            apgi_pkg::J_NEXT:     jump = 1'b0;
            apgi_pkg::J_ALWAYS:   jump = 1'b1;
            apgi_pkg::J_NO_PREV:  jump = !have_prev_reg;
            apgi_pkg::J_ANY_ZERO: jump = any_zero;
            apgi_pkg::J_NOT_EQ:   jump = !a_eq_b;
            default:              jump = 1'b0;
        endcase
    end

    always_comb
    begin
        upc_next       = upc_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        k_next         = k_reg;
        cur_next       = cur_reg;
        cur_last_next  = cur_last_reg;
        prev_next      = prev_reg;
        have_prev_next = have_prev_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        out_gcd_next   = out_gcd_reg;
        out_last_next  = out_last_reg;

        if (!stall)
        begin
            upc_next = jump ? uw.target : apgi_pkg::upc_t'(upc_reg + 1'b1);
            case (uw.op)
                apgi_pkg::OP_LOAD:
                begin
                    a_next        = prev_reg;
                    b_next        = s_axis_tdata[apgi_pkg::VALUE_BITS-1:0];
                    k_next        = '0;
                    cur_next      = s_axis_tdata[apgi_pkg::VALUE_BITS-1:0];
                    cur_last_next = s_axis_tlast;
                end
                apgi_pkg::OP_ZERO:
                begin
                    // gcd(0,b) = b, gcd(a,0) = a already in a
                    if (a_reg == '0)
                    begin
                        a_next = b_reg;
                    end
                end
                apgi_pkg::OP_STEP:
                begin
                    if (!a_eq_b)
                    begin
                        if (!a_reg[0] && !b_reg[0])
                        begin
                            a_next = a_reg >> 1;
                            b_next = b_reg >> 1;
                            k_next = apgi_pkg::shift_t'(k_reg + 1'b1);
                        end
                        else if (!a_reg[0])
                        begin
                            a_next = a_reg >> 1;
                        end
                        else if (!b_reg[0])
                        begin
                            b_next = b_reg >> 1;
                        end
                        else if (a_lt_b)
                        begin
                            b_next = b_minus_a;
                        end
                        else
                        begin
                            a_next = a_minus_b;
                        end
                    end
                end
                apgi_pkg::OP_FINISH:
                begin
                    // restore the common power of two
                    a_next = a_reg << k_reg;
                end
                apgi_pkg::OP_EMIT_GCD:
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = a_reg;
                    out_gcd_next   = 1'b1;
                    out_last_next  = 1'b0;
                end
                apgi_pkg::OP_EMIT_ELEM:
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = cur_reg;
                    out_gcd_next   = 1'b0;
                    out_last_next  = cur_last_reg;
                    prev_next      = cur_last_reg ? '0 : cur_reg;
                    have_prev_next = !cur_last_reg;
                end
                default:
                begin
                    upc_next = apgi_pkg::STEP_LOAD;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg       <= apgi_pkg::STEP_LOAD;
            out_valid_reg <= 1'b0;
            prev_reg      <= '0;
            have_prev_reg <= 1'b0;
            k_reg         <= '0;
        end
        else
        begin
            upc_reg       <= upc_next;
            out_valid_reg <= out_valid_next;
            prev_reg      <= prev_next;
            have_prev_reg <= have_prev_next;
            k_reg         <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg        <= a_next;
        b_reg        <= b_next;
        cur_reg      <= cur_next;
        cur_last_reg <= cur_last_next;
        out_data_reg <= out_data_next;
        out_gcd_reg  <= out_gcd_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = apgi_pkg::TDATA_BITS'(out_data_reg);
    assign m_axis_tuser  = out_gcd_reg;
    assign m_axis_tlast  = out_last_reg;

    // both operands stay nonzero inside the gcd loop
    assert property (@(posedge clk) disable iff (!rst_n)
        (upc_reg == apgi_pkg::STEP_LOOP) |-> (a_reg != '0) && (b_reg != '0))
        else $error("gcd loop operand became zero");

    // common power-of-two count stays below the value width
    assert property (@(posedge clk) disable iff (!rst_n)
        (upc_reg == apgi_pkg::STEP_LOOP) |-> (k_reg < apgi_pkg::VALUE_BITS))
        else $error("gcd shift count overflow");

    // an inserted gcd never closes a sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> !m_axis_tlast)
        else $error("gcd result marked last");

    // first element of a sequence goes straight to the element emit step
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && !have_prev_reg)
        |=> (upc_reg == apgi_pkg::STEP_ELEM))
        else $error("first element did not bypass gcd");

endmodule

/* bench/tb_adjacent_pair_gcd_interleave.sv */
`timescale 1ns / 100ps

module tb_adjacent_pair_gcd_interleave;

    localparam int RANDOM_ITEMS = 800;
    localparam int NUM_ROWS     = 22;

    typedef struct packed
    {
        apgi_pkg::value_t value;
        logic             is_gcd;
        logic             last;
    } seq_result_t;

    // one directed transaction; known rows carry the gcd typed in
    typedef struct packed
    {
        logic [apgi_pkg::TDATA_BITS-1:0] data;
        logic                            last;
        logic                            known;
        logic                            with_gcd;
        apgi_pkg::value_t                gcd;
    } stim_row_t;

    localparam stim_row_t STIM_ROWS [NUM_ROWS] = '{
        '{32'h0000_0000, 1'b0, 1'b1, 1'b0, 31'd0},          // first after reset
        '{32'h0000_0000, 1'b0, 1'b1, 1'b1, 31'd0},          // both zero
        '{32'h0000_000C, 1'b0, 1'b1, 1'b1, 31'd12},         // zero and 12
        '{32'h0000_0000, 1'b0, 1'b1, 1'b1, 31'd12},
        '{32'h7FFF_FFFF, 1'b0, 1'b1, 1'b1, 31'h7FFF_FFFF},
        '{32'h7FFF_FFFF, 1'b0, 1'b1, 1'b1, 31'h7FFF_FFFF},
        '{32'h0000_0001, 1'b1, 1'b1, 1'b1, 31'd1},
        '{32'h0000_0005, 1'b1, 1'b1, 1'b0, 31'd0},          // single element
        '{32'h7FFF_FFFF, 1'b1, 1'b1, 1'b0, 31'd0},
        '{32'h0000_0030, 1'b0, 1'b0, 1'b0, 31'd0},
        '{32'h0000_0012, 1'b0, 1'b0, 1'b0, 31'd0},
        '{32'h7FFF_FFFE, 1'b0, 1'b0, 1'b0, 31'd0},
        '{32'h4000_0000, 1'b0, 1'b0, 1'b0, 31'd0},
        '{32'h8000_0009, 1'b0, 1'b0, 1'b0, 31'd0},          // pad bit set
        '{32'h0000_0003, 1'b1, 1'b0, 1'b0, 31'd0},
        '{32'h6D73_E55F, 1'b0, 1'b0, 1'b0, 31'd0},          // fibonacci
        '{32'h43A5_3F82, 1'b0, 1'b0, 1'b0, 31'd0},
        '{32'h29CE_A5DD, 1'b1, 1'b0, 1'b0, 31'd0},
        '{32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0, 31'd0},
        '{32'h7FFF_FFED, 1'b0, 1'b0, 1'b0, 31'd0},
        '{32'h4000_0000, 1'b1, 1'b0, 1'b0, 31'd0},
        '{32'h0000_0000, 1'b1, 1'b1, 1'b0, 31'd0}           // single zero
    };

    logic                            clk           = 1'b0;
    logic                            rst_n         = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [apgi_pkg::TDATA_BITS-1:0] s_axis_tdata  = '0;
    logic                            s_axis_tlast  = 1'b0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [apgi_pkg::TDATA_BITS-1:0] m_axis_tdata;
    logic                            m_axis_tuser;
    logic                            m_axis_tlast;

    seq_result_t      expected_results [$];
    apgi_pkg::value_t prev_element;
    logic             have_prev;
    int               error_count = 0;
    int               burst_left;
    int unsigned      cycle_count = 0;
    int unsigned      stall_mode  = 0;

    adjacent_pair_gcd_interleave DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic apgi_pkg::value_t gcd_by_remainder(input apgi_pkg::value_t a,
                                                          input apgi_pkg::value_t b);
        apgi_pkg::value_t x;
        apgi_pkg::value_t y;
        apgi_pkg::value_t r;
        x = a;
        y = b;
        while (y != '0)
        begin
            r = x % y;
            x = y;
            y = r;
        end
        return x;
    endfunction

    // advances the sequence state and queues what the block must emit
    task automatic predict_sequence(input apgi_pkg::value_t v, input logic last_in,
                                    input logic known, input logic with_gcd,
                                    input apgi_pkg::value_t typed_gcd);
        if (known)
        begin
            if (with_gcd)
                expected_results.push_back({typed_gcd, 1'b1, 1'b0});
        end
        else if (have_prev)
        begin
            expected_results.push_back({gcd_by_remainder(prev_element, v), 1'b1, 1'b0});
        end
        expected_results.push_back({v, 1'b0, last_in});
        if (last_in)
        begin
            prev_element = '0;
            have_prev    = 1'b0;
        end
        else
        begin
            prev_element = v;
            have_prev    = 1'b1;
        end
    endtask

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task automatic check_result(input apgi_pkg::value_t got_value, input logic got_gcd,
                                input logic got_last);
        seq_result_t want;
        if (expected_results.size() == 0)
        begin
            report_mismatch($sformatf("unexpected transaction value=%0d is_gcd=%0b last=%0b",
                                      got_value, got_gcd, got_last));
        end
        else
        begin
            want = expected_results.pop_front();
            if (got_value !== want.value || got_gcd !== want.is_gcd
                || got_last !== want.last)
                report_mismatch($sformatf(
                    "expected value=%0d is_gcd=%0b last=%0b, got value=%0d is_gcd=%0b last=%0b",
                    want.value, want.is_gcd, want.last, got_value, got_gcd, got_last));
        end
    endtask

    // bursts of transactions separated by random gaps
    task automatic send_item(input logic [apgi_pkg::TDATA_BITS-1:0] data,
                             input logic last_in);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 6);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tlast  <= last_in;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    function automatic apgi_pkg::value_t pick_value(input int unsigned factor);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return apgi_pkg::value_t'($urandom_range(0, 20));
            3:       return apgi_pkg::value_t'(1)
                            << $urandom_range(0, apgi_pkg::VALUE_BITS - 1);
            4, 5, 6: return apgi_pkg::value_t'(factor * $urandom_range(0, 2000000));
            default: return apgi_pkg::value_t'($urandom());
        endcase
    endfunction

    // receiver: checks accepted results under a randomly chosen stall pattern
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_result(m_axis_tdata[apgi_pkg::VALUE_BITS-1:0], m_axis_tuser,
                             m_axis_tlast);
            cycle_count <= cycle_count + 1;
            if (cycle_count % 50 == 0)
                stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= 1'($urandom_range(0, 1));
                2:       m_axis_tready <= (cycle_count[1:0] == 2'd0);
                default: m_axis_tready <= ($urandom_range(0, 4) != 0);
            endcase
        end
    end

    initial
    begin
        int                              sent;
        int                              seq_len;
        int                              k;
        int unsigned                     factor;
        logic [apgi_pkg::TDATA_BITS-1:0] data;
        logic                            last_in;

        prev_element = '0;
        have_prev    = 1'b0;
        burst_left   = 0;
        sent         = 0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_ROWS; i++)
        begin
            send_item(STIM_ROWS[i].data, STIM_ROWS[i].last);
            predict_sequence(STIM_ROWS[i].data[apgi_pkg::VALUE_BITS-1:0], STIM_ROWS[i].last,
                             STIM_ROWS[i].known, STIM_ROWS[i].with_gcd, STIM_ROWS[i].gcd);
        end

        while (sent < RANDOM_ITEMS)
        begin
            seq_len = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 8);
            factor  = $urandom_range(1, 1000);
            for (k = 0; k < seq_len; k++)
            begin
                data    = {($urandom_range(0, 7) == 0), pick_value(factor)};
                last_in = (k == seq_len - 1);
                send_item(data, last_in);
                predict_sequence(data[apgi_pkg::VALUE_BITS-1:0], last_in, 1'b0, 1'b0, '0);
                sent++;
                if (sent == RANDOM_ITEMS / 2)
                begin
                    // hold off mid-sequence until the block has drained
                    s_axis_tvalid <= 1'b0;
                    do
                        @(posedge clk);
                    while (expected_results.size() != 0);
                    burst_left = 0;
                end
            end
        end

        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);

        if (error_count == 0)
            $display("** adjacent_pair_gcd_interleave: PASSED **");
        else
            $display("** adjacent_pair_gcd_interleave: FAILED **");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("** adjacent_pair_gcd_interleave: FAILED **");
        $finish;
    end

endmodule

/* adjacent_pair_gcd_interleave.f */
rtl/apgi_pkg.sv
rtl/adjacent_pair_gcd_interleave.sv
bench/tb_adjacent_pair_gcd_interleave.sv
